// ----- hdl/rv64_exec_pkg.sv -----
// Package for the RV64I execute pipeline: transaction types, opcode and cause codes.
// No dependencies.
package rv64_exec_pkg;

   localparam int WIDE = 64;

   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6f;
   localparam logic [6:0] OP_SYSTEM = 7'h73;
   localparam logic [6:0] OP_FENCE  = 7'h0f;

   localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
   localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

   localparam logic [2:0] CAUSE_CLEAR   = 3'd0;
   localparam logic [2:0] CAUSE_UCALL   = 3'd1;
   localparam logic [2:0] CAUSE_SCALL   = 3'd2;
   localparam logic [2:0] CAUSE_MCALL   = 3'd3;
   localparam logic [2:0] CAUSE_BREAK   = 3'd4;
   localparam logic [2:0] CAUSE_ILLEGAL = 3'd5;

   localparam logic [1:0] MODE_USER  = 2'd0;
   localparam logic [1:0] MODE_SUPER = 2'd1;
   localparam logic [1:0] MODE_MACH  = 2'd3;

   // ALU selects
   typedef enum logic [3:0] {
      ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU, ALU_XOR,
      ALU_SRL, ALU_SRA, ALU_OR, ALU_AND, ALU_PASS_B
   } alu_op_type;

   typedef enum logic [1:0] {
      RES_ALU, RES_LINK, RES_NONE
   } res_sel_type;

   typedef struct packed {
      logic [31:0] instruction_word;
      logic [63:0] current_pc;
      logic [63:0] source_one_value;
      logic [63:0] source_two_value;
      logic [1:0]  privilege_mode;
   } req_type;

   typedef struct packed {
      logic        reg_write;
      logic [4:0]  dest_index;
      logic [63:0] dest_value;
      logic [63:0] following_pc;
      logic [2:0]  cause_code;
      logic        mem_load;
      logic        mem_store;
      logic [63:0] mem_address;
      logic [2:0]  mem_bytes;
      logic        mem_sign_extend;
      logic [63:0] store_value;
      logic [63:0] trap_value;
   } rsp_type;

   // decoded control passed from decode to execute
   typedef struct packed {
      logic        reg_write;
      logic [4:0]  rd;
      alu_op_type  alu_op;
      logic        alu_b_imm;     // operand b is immediate, else rs2
      logic        alu_a_pc;      // operand a is pc (auipc)
      logic        is_branch;
      logic [2:0]  f3;
      logic        is_jal;
      logic        is_jalr;
      logic        mem_load;
      logic        mem_store;
      logic [2:0]  mem_bytes;
      logic        mem_sign;
      logic [2:0]  cause;
   } ctrl_type;

endpackage

// ----- hdl/rv64_exec_decode.sv -----
// Stage 1: decodes the instruction word into control and a sign-extended immediate.
// Depends on rv64_exec_pkg.
module rv64_exec_decode #(
   parameter int XLEN = 64
) (
   input  logic [31:0]                 instr,
   input  logic [1:0]                  mode,
   output rv64_exec_pkg::ctrl_type     ctrl,
   output logic [XLEN-1:0]             imm,
   output logic [XLEN-1:0]             br_off
);
   import rv64_exec_pkg::*;

   logic [6:0] op;
   logic [2:0] f3;
   logic [6:0] f7;
   logic [5:0] f6;
   logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_j, imm_u;

   assign op = instr[6:0];
   assign f3 = instr[14:12];
   assign f7 = instr[31:25];
   assign f6 = instr[31:26];
   assign imm_i = {{(XLEN-11){instr[31]}}, instr[30:20]};
   assign imm_s = {{(XLEN-11){instr[31]}}, instr[30:25], instr[11:7]};
   assign imm_b = {{(XLEN-12){instr[31]}}, instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_j = {{(XLEN-20){instr[31]}}, instr[19:12], instr[20], instr[30:21], 1'b0};
   assign imm_u = {{(XLEN-31){instr[31]}}, instr[30:12], 12'h000};

   function automatic alu_op_type f3_op(input logic [2:0] f, input logic alt);
      alu_op_type r;
      case (f)
         3'd0: r = alt ? ALU_SUB : ALU_ADD;
         3'd1: r = ALU_SLL;
         3'd2: r = ALU_SLT;
         3'd3: r = ALU_SLTU;
         3'd4: r = ALU_XOR;
         3'd5: r = alt ? ALU_SRA : ALU_SRL;
         3'd6: r = ALU_OR;
         default: r = ALU_AND;
      endcase
      return r;
   endfunction

   always_comb begin
      ctrl = '0;
      ctrl.alu_op = ALU_ADD;
      ctrl.rd = instr[11:7];
      ctrl.f3 = f3;
      imm = imm_i;
      br_off = imm_b;
      case (op)
         OP_REG: begin
            if (f7 == 7'h00 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5))) begin
               ctrl.reg_write = 1'b1;
               ctrl.alu_op = f3_op(f3, f7[5]);
            end else begin
               ctrl.cause = CAUSE_ILLEGAL;
            end
         end
         OP_IMM: begin
            ctrl.alu_b_imm = 1'b1;
            if (f3 == 3'd1) begin
               if (f6 == 6'h00) begin
                  ctrl.reg_write = 1'b1;
                  ctrl.alu_op = ALU_SLL;
               end else begin
                  ctrl.cause = CAUSE_ILLEGAL;
               end
            end else if (f3 == 3'd5) begin
               if (f6 == 6'h00 || f6 == 6'h10) begin
                  ctrl.reg_write = 1'b1;
                  ctrl.alu_op = f6[4] ? ALU_SRA : ALU_SRL;
               end else begin
                  ctrl.cause = CAUSE_ILLEGAL;
               end
            end else begin
               ctrl.reg_write = 1'b1;
               ctrl.alu_op = f3_op(f3, 1'b0);
            end
         end
         OP_LOAD: begin
            if (f3 == 3'd3 || f3 >= 3'd6) begin
               ctrl.cause = CAUSE_ILLEGAL;
            end else begin
               ctrl.mem_load = 1'b1;
               ctrl.mem_bytes = 3'(1 << f3[1:0]);
               ctrl.mem_sign = ~f3[2];
            end
         end
         OP_STORE: begin
            imm = imm_s;
            if (f3 > 3'd2) begin
               ctrl.cause = CAUSE_ILLEGAL;
            end else begin
               ctrl.mem_store = 1'b1;
               ctrl.mem_bytes = 3'(1 << f3[1:0]);
            end
         end
         OP_JALR: begin
            if (f3 != 3'd0) begin
               ctrl.cause = CAUSE_ILLEGAL;
            end else begin
               ctrl.reg_write = 1'b1;
               ctrl.is_jalr = 1'b1;
            end
         end
         OP_BRANCH: begin
            if (f3 == 3'd2 || f3 == 3'd3) begin
               ctrl.cause = CAUSE_ILLEGAL;
            end else begin
               ctrl.is_branch = 1'b1;
            end
         end
         OP_LUI: begin
            imm = imm_u;
            ctrl.reg_write = 1'b1;
            ctrl.alu_b_imm = 1'b1;
            ctrl.alu_op = ALU_PASS_B;
         end
         OP_AUIPC: begin
            imm = imm_u;
            ctrl.reg_write = 1'b1;
            ctrl.alu_b_imm = 1'b1;
            ctrl.alu_a_pc = 1'b1;
         end
         OP_JAL: begin
            br_off = imm_j;
            ctrl.reg_write = 1'b1;
            ctrl.is_jal = 1'b1;
         end
         OP_SYSTEM: begin
            if (instr == WORD_ECALL) begin
               case (mode)
                  MODE_USER:  ctrl.cause = CAUSE_UCALL;
                  MODE_SUPER: ctrl.cause = CAUSE_SCALL;
                  MODE_MACH:  ctrl.cause = CAUSE_MCALL;
                  default:    ctrl.cause = CAUSE_CLEAR;
               endcase
            end else if (instr == WORD_EBREAK) begin
               ctrl.cause = CAUSE_BREAK;
            end else begin
               ctrl.cause = CAUSE_ILLEGAL;
            end
         end
         OP_FENCE: begin
            if (f3 != 3'd0) ctrl.cause = CAUSE_ILLEGAL;
         end
         default: ctrl.cause = CAUSE_ILLEGAL;
      endcase
   end

endmodule

// ----- hdl/rv64_exec_alu.sv -----
// Stage 2 logic: ALU, branch compare, address and target adders.
// Depends on rv64_exec_pkg.
module rv64_exec_alu #(
   parameter int XLEN = 64
) (
   input  rv64_exec_pkg::ctrl_type ctrl,
   input  logic [XLEN-1:0]         pc,
   input  logic [XLEN-1:0]         a,
   input  logic [XLEN-1:0]         b,
   input  logic [XLEN-1:0]         imm,
   input  logic [XLEN-1:0]         br_off,
   output logic [XLEN-1:0]         result,
   output logic [XLEN-1:0]         next_pc,
   output logic [XLEN-1:0]         addr
);
   import rv64_exec_pkg::*;

   localparam int SH_W = $clog2(XLEN);

   logic [XLEN-1:0] opa, opb, seq_pc, sum;
   logic [SH_W-1:0] sh;
   logic            lt_s, lt_u, eq, taken;

   assign opa = ctrl.alu_a_pc ? pc : a;
   assign opb = ctrl.alu_b_imm ? imm : b;
   assign sh = opb[SH_W-1:0];
   assign sum = a + imm;
   assign addr = sum;
   assign seq_pc = pc + XLEN'(4);
   assign lt_s = $signed(opa) < $signed(opb);
   assign lt_u = opa < opb;
   assign eq = (a == b);

   always_comb begin
      case (ctrl.alu_op)
         ALU_ADD:    result = opa + opb;
         ALU_SUB:    result = opa - opb;
         ALU_SLL:    result = opa << sh;
         ALU_SLT:    result = XLEN'(lt_s);
         ALU_SLTU:   result = XLEN'(lt_u);
         ALU_XOR:    result = opa ^ opb;
         ALU_SRL:    result = opa >> sh;
         ALU_SRA:    result = XLEN'($signed(opa) >>> sh);
         ALU_OR:     result = opa | opb;
         ALU_AND:    result = opa & opb;
         ALU_PASS_B: result = opb;
         default:    result = '0;
      endcase
      if (ctrl.is_jal || ctrl.is_jalr) result = seq_pc;

      case (ctrl.f3)
         3'd0: taken = eq;
         3'd1: taken = ~eq;
         3'd4: taken = lt_s;
         3'd5: taken = ~lt_s;
         3'd6: taken = lt_u;
         3'd7: taken = ~lt_u;
         default: taken = 1'b0;
      endcase

      if (ctrl.is_jalr) next_pc = {sum[XLEN-1:1], 1'b0};
      else if (ctrl.is_jal || (ctrl.is_branch && taken)) next_pc = pc + br_off;
      else next_pc = seq_pc;
   end

endmodule

// ----- hdl/rv64i_base_integer_execute_top.sv -----
// Top level of the RV64I execute pipeline: decode, execute and output stages.
// Depends on rv64_exec_pkg, rv64_exec_decode and rv64_exec_alu.
//
// Usage: one instruction transaction per cycle enters on req_ (valid/ready)
// with pc, rs1/rs2 values and privilege mode. Exactly one result transaction
// leaves on rsp_ per instruction, in order.
// Path: a transaction passes the input register, decode register and
// execute register before rsp_valid rises; throughput one transaction per
// cycle while rsp_ready does not stall the output stage.
// The pipeline advances wherever a stage is empty or the stage after it
// moves, so bubbles collapse; a stall on rsp_ready holds each full stage
// with no empty stage after it; req_ready drops only with all three full.
// The critical path per stage is one 64-bit add or shift plus selection.
// Reset (synchronous, active high) empties all stages; payload is not cleared.
// No configuration, no state between instructions.
module rv64i_base_integer_execute_top #(
   parameter int XLEN = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rv64_exec_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rv64_exec_pkg::rsp_type rsp_data
);
   import rv64_exec_pkg::*;

   // stage 1: input register
   logic      s1_v_ff, s1_v_in;
   req_type   s1_d_ff;
   // stage 2: decoded
   logic            s2_v_ff, s2_v_in;
   ctrl_type        s2_c_ff;
   logic [XLEN-1:0] s2_imm_ff, s2_off_ff, s2_pc_ff, s2_a_ff, s2_b_ff;
   // stage 3: result
   logic      s3_v_ff, s3_v_in;
   rsp_type   s3_d_ff, s3_d_in;

   logic adv1, adv2, adv3;
   ctrl_type        dec_c;
   logic [XLEN-1:0] dec_imm, dec_off, ex_res, ex_npc, ex_addr;

   assign adv3 = ~s3_v_ff | rsp_ready;
   assign adv2 = ~s2_v_ff | adv3;
   assign adv1 = ~s1_v_ff | adv2;
   assign req_ready = adv1;

   assign s1_v_in = adv1 ? req_valid : s1_v_ff;
   assign s2_v_in = adv2 ? s1_v_ff : s2_v_ff;
   assign s3_v_in = adv3 ? s2_v_ff : s3_v_ff;

   rv64_exec_decode #(.XLEN(XLEN)) u_dec (
      .instr (s1_d_ff.instruction_word),
      .mode  (s1_d_ff.privilege_mode),
      .ctrl  (dec_c),
      .imm   (dec_imm),
      .br_off(dec_off)
   );

   rv64_exec_alu #(.XLEN(XLEN)) u_alu (
      .ctrl   (s2_c_ff),
      .pc     (s2_pc_ff),
      .a      (s2_a_ff),
      .b      (s2_b_ff),
      .imm    (s2_imm_ff),
      .br_off (s2_off_ff),
      .result (ex_res),
      .next_pc(ex_npc),
      .addr   (ex_addr)
   );

   always_comb begin
      logic [XLEN-1:0] seq;
      logic            trap;
      seq = s2_pc_ff + XLEN'(4);
      trap = (s2_c_ff.cause != CAUSE_CLEAR);
      s3_d_in = '0;
      s3_d_in.cause_code = s2_c_ff.cause;
      s3_d_in.following_pc = WIDE'(trap ? seq : ex_npc);
      if (!trap) begin
         s3_d_in.reg_write = s2_c_ff.reg_write;
         if (s2_c_ff.reg_write || s2_c_ff.mem_load) s3_d_in.dest_index = s2_c_ff.rd;
         if (s2_c_ff.reg_write) s3_d_in.dest_value = WIDE'(ex_res);
         s3_d_in.mem_load = s2_c_ff.mem_load;
         s3_d_in.mem_store = s2_c_ff.mem_store;
         if (s2_c_ff.mem_load || s2_c_ff.mem_store) begin
            s3_d_in.mem_address = WIDE'(ex_addr);
            s3_d_in.mem_bytes = s2_c_ff.mem_bytes;
         end
         s3_d_in.mem_sign_extend = s2_c_ff.mem_sign;
         if (s2_c_ff.mem_store) s3_d_in.store_value = WIDE'(s2_b_ff);
      end
      if (s2_c_ff.cause == CAUSE_BREAK) s3_d_in.trap_value = WIDE'(s2_pc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) s1_d_ff <= req_data;
      if (adv2) begin
         s2_c_ff   <= dec_c;
         s2_imm_ff <= dec_imm;
         s2_off_ff <= dec_off;
         s2_pc_ff  <= s1_d_ff.current_pc[XLEN-1:0];
         s2_a_ff   <= s1_d_ff.source_one_value[XLEN-1:0];
         s2_b_ff   <= s1_d_ff.source_two_value[XLEN-1:0];
      end
      if (adv3) s3_d_ff <= s3_d_in;
   end

   assign rsp_valid = s3_v_ff;
   assign rsp_data  = s3_d_ff;

   // a stalled output holds its result
   a_hold: assert property (@(posedge clock) disable iff (reset)
      s3_v_ff && !rsp_ready |=> s3_v_ff && $stable(s3_d_ff))
      else $error("result changed while stalled");

   // input is refused only when every stage is full
   a_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_v_ff && s2_v_ff && s3_v_ff)
      else $error("input refused with an empty stage");

   // a trapping result never carries register or memory effects
   a_trap: assert property (@(posedge clock) disable iff (reset)
      s3_v_ff && s3_d_ff.cause_code != CAUSE_CLEAR |->
         !s3_d_ff.reg_write && !s3_d_ff.mem_load && !s3_d_ff.mem_store)
      else $error("trap with side effect");

endmodule
